// ===== src/atc_pkg.sv =====
// Shared types, codes and helpers for the associative tag cache.
// Used by atc_victim, assoc_tag_cache_random_replace, atc_reply_checker and tb.
package atc_pkg;

	localparam int OBJ_ID_W   = 16;
	localparam int SLOT_OUT_W = 6;
	localparam int MODE_W     = 3;
	localparam int SEED_W     = 16;

	localparam logic [MODE_W-1:0] MODE_LOOKUP = 3'd0;
	localparam logic [MODE_W-1:0] MODE_FREE   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_MARK   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_FLUSH  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

	localparam logic [SEED_W-1:0] LFSR_TAPS  = 16'hB400;
	localparam logic [SEED_W-1:0] LFSR_RESET = 16'd1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_VREAD,
		ST_FIN
	} st_t;

	typedef struct packed {
		logic              start;
		logic              commit;
		logic              load;
		logic [SEED_W-1:0] seed;
	} vic_ctrl_t;

	function automatic logic [SEED_W-1:0] lfsr_step(input logic [SEED_W-1:0] s);
		logic [SEED_W-1:0] n;
		n = s >> 1;
		if (s[0]) begin
			n = n ^ LFSR_TAPS;
		end
		return n;
	endfunction

endpackage

// ===== src/atc_tag_ram.sv =====
// Identifier store: one write port, one read port with registered data.
// No dependencies.
module atc_tag_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/atc_victim.sv =====
// Victim generator: Galois LFSR and a two-stage reciprocal-multiply remainder unit.
// Depends on atc_pkg.
module atc_victim import atc_pkg::*; #(
	parameter int CACHE_ENTRIES  = 64,
	parameter int RESERVED_SLOTS = 10
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  vic_ctrl_t                        ctrl,
	output logic [$clog2(CACHE_ENTRIES)-1:0] victim
);

	localparam int SLOT_W = $clog2(CACHE_ENTRIES);
	localparam int SPAN   = CACHE_ENTRIES - RESERVED_SLOTS;
	localparam int RCP_SH = SEED_W + SLOT_W;
	localparam int RCP_W  = RCP_SH + 1;
	localparam int PROD_W = SEED_W + RCP_W;
	localparam int BACK_W = SEED_W + SLOT_W;
	localparam logic [RCP_W-1:0] RCP =
		RCP_W'(((64'd1 << RCP_SH) + 64'(SPAN) - 64'd1) / 64'(SPAN));

	logic [SEED_W-1:0] lfsr_q;
	logic [SEED_W-1:0] nxt_q;
	logic [SEED_W-1:0] quot_s1;
	logic [SLOT_W-1:0] rem_s2;
	logic [PROD_W-1:0] prod;
	logic [BACK_W-1:0] diff;

	assign prod   = PROD_W'(nxt_q) * PROD_W'(RCP);
	assign diff   = BACK_W'(nxt_q) - BACK_W'(quot_s1) * BACK_W'(SPAN);
	assign victim = SLOT_W'(RESERVED_SLOTS) + rem_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfsr_q <= LFSR_RESET;
		end else begin
			if (ctrl.load) begin
				lfsr_q <= (ctrl.seed == '0) ? LFSR_RESET : ctrl.seed;
			end else if (ctrl.commit) begin
				lfsr_q <= nxt_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			nxt_q <= lfsr_step(lfsr_q);
		end
		quot_s1 <= prod[RCP_SH +: SEED_W];
		rem_s2  <= diff[SLOT_W-1:0];
	end

endmodule

// ===== src/assoc_tag_cache_random_replace.sv =====
// Fully associative tag cache with pseudo-random replacement.
// Lookup, free and mark: the result follows the one-slot-a-cycle scan of the identifier
// RAM; a lookup that must evict also reads the victim's identifier before its result.
// Flush: one result per dirty slot (a single result if none); the scan stalls on the output.
// Clear and unused modes skip the scan. Next transfer in the cycle after the last result loads.
// Async reset clears valid/dirty bits and sets seed and LFSR to 1.
module assoc_tag_cache_random_replace import atc_pkg::*; #(
	parameter int CACHE_ENTRIES  = 64,
	parameter int RESERVED_SLOTS = 10,
	parameter int ID_BITS        = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [15:0] object_id
	input  logic [2:0]  s_tuser,  // [2:0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // hit, slot[6], slot_known, fetch_needed,
	                              // writeback_valid, writeback_id[16], zero pad
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int SLOT_W = $clog2(CACHE_ENTRIES);
	localparam int CNT_W  = SLOT_W + 1;

	st_t                      state_q, state_d;
	logic [MODE_W-1:0]        mode_q;
	logic [ID_BITS-1:0]       id_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [SLOT_W-1:0]        idx_s1;
	logic                     vld_s1;
	logic                     found_q, free_found_q, pend_q;
	logic [SLOT_W-1:0]        found_slot_q, free_slot_q, pend_slot_q;
	logic [ID_BITS-1:0]       pend_id_q;
	logic [CACHE_ENTRIES-1:0] valid_q, dirty_q;
	logic [SEED_W-1:0]        seed_q;

	logic                     out_valid_q;
	logic                     hit_q, known_q, fetch_q, wbv_q, last_q;
	logic [SLOT_OUT_W-1:0]    slot_q;
	logic [OBJ_ID_W-1:0]      wbid_q;

	logic [MODE_W-1:0]        s_mode;
	logic                     acc, out_free, out_ld, fin_go, stall, issuing;
	logic                     hit_now, dv_now, cfg_wr;
	logic                     res_hit, res_known, res_fetch, res_wbv, res_last;
	logic [SLOT_W-1:0]        res_slot;
	logic [OBJ_ID_W-1:0]      res_wbid;
	logic                     ram_we;
	logic [SLOT_W-1:0]        ram_waddr, ram_raddr, victim;
	logic [ID_BITS-1:0]       rdata;
	logic                     vic_commit;
	vic_ctrl_t                vic;

	assign s_mode   = s_tuser;
	assign s_tready = (state_q == ST_IDLE);
	assign acc      = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign issuing  = cnt_q < CNT_W'(CACHE_ENTRIES);
	assign hit_now  = valid_q[idx_s1] && (rdata == id_q);
	assign dv_now   = valid_q[idx_s1] && dirty_q[idx_s1];
	assign cfg_wr   = psel && penable && pwrite && pready;

	assign pready = 1'b1;
	assign prdata = paddr[2] ? '0 : 32'(seed_q);

	assign vic = '{start: acc && (s_mode == MODE_LOOKUP), commit: vic_commit,
		load: cfg_wr && !paddr[2], seed: pwdata[SEED_W-1:0]};
	assign ram_raddr  = (state_q == ST_SCAN) ? (stall ? idx_s1 : cnt_q[SLOT_W-1:0]) : victim;

	atc_tag_ram #(
		.DEPTH (CACHE_ENTRIES),
		.WIDTH (ID_BITS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (id_q),
		.raddr (ram_raddr),
		.rdata (rdata)
	);

	atc_victim #(
		.CACHE_ENTRIES  (CACHE_ENTRIES),
		.RESERVED_SLOTS (RESERVED_SLOTS)
	) u_victim (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (vic),
		.victim (victim)
	);

	always_comb begin
		state_d    = state_q;
		out_ld     = 1'b0;
		fin_go     = 1'b0;
		stall      = 1'b0;
		ram_we     = 1'b0;
		ram_waddr  = victim;
		vic_commit = 1'b0;
		res_hit    = 1'b0;
		res_slot   = '0;
		res_known  = 1'b0;
		res_fetch  = 1'b0;
		res_wbv    = 1'b0;
		res_wbid   = '0;
		res_last   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					if (s_mode != MODE_CLEAR && s_mode <= MODE_FLUSH) begin
						state_d = ST_SCAN;
					end else begin
						state_d = ST_FIN;
					end
				end
			end
			ST_SCAN: begin
				if (mode_q == MODE_FLUSH && vld_s1 && dv_now && pend_q) begin
					res_slot  = pend_slot_q;
					res_known = 1'b1;
					res_wbv   = 1'b1;
					res_wbid  = OBJ_ID_W'(pend_id_q);
					if (out_free) begin
						out_ld = 1'b1;
					end else begin
						stall = 1'b1;
					end
				end
				if (!issuing && !vld_s1) begin
					if (mode_q == MODE_LOOKUP && !found_q && !free_found_q) begin
						state_d = ST_VREAD;
					end else begin
						state_d = ST_FIN;
					end
				end
			end
			ST_VREAD: begin
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (out_free) begin
					fin_go   = 1'b1;
					out_ld   = 1'b1;
					res_last = 1'b1;
					state_d  = ST_IDLE;
					case (mode_q)
						MODE_LOOKUP: begin
							res_known = 1'b1;
							if (found_q) begin
								res_hit  = 1'b1;
								res_slot = found_slot_q;
							end else if (free_found_q) begin
								res_slot  = free_slot_q;
								res_fetch = 1'b1;
								ram_we    = 1'b1;
								ram_waddr = free_slot_q;
							end else begin
								res_slot   = victim;
								res_fetch  = 1'b1;
								res_wbv    = dirty_q[victim];
								res_wbid   = dirty_q[victim] ? OBJ_ID_W'(rdata) : '0;
								ram_we     = 1'b1;
								ram_waddr  = victim;
								vic_commit = 1'b1;
							end
						end
						MODE_FREE, MODE_MARK: begin
							if (found_q) begin
								res_hit   = 1'b1;
								res_known = 1'b1;
								res_slot  = found_slot_q;
							end
						end
						MODE_FLUSH: begin
							if (pend_q) begin
								res_slot  = pend_slot_q;
								res_known = 1'b1;
								res_wbv   = 1'b1;
								res_wbid  = OBJ_ID_W'(pend_id_q);
							end
						end
						default: begin
						end
					endcase
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			vld_s1       <= 1'b0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			pend_q       <= 1'b0;
			valid_q      <= '0;
			dirty_q      <= '0;
			seed_q       <= LFSR_RESET;
			out_valid_q  <= 1'b0;
		end else begin
			if (acc) begin
				cnt_q        <= '0;
				vld_s1       <= 1'b0;
				found_q      <= 1'b0;
				free_found_q <= 1'b0;
				pend_q       <= 1'b0;
			end else if (state_q == ST_SCAN && !stall) begin
				if (issuing) begin
					cnt_q  <= cnt_q + 1'b1;
					vld_s1 <= 1'b1;
				end else begin
					vld_s1 <= 1'b0;
				end
				if (vld_s1) begin
					if (hit_now) begin
						found_q <= 1'b1;
					end
					if (!valid_q[idx_s1]) begin
						free_found_q <= 1'b1;
					end
					if (dv_now) begin
						pend_q <= 1'b1;
					end
				end
			end
			if (fin_go) begin
				case (mode_q)
					MODE_LOOKUP: begin
						if (ram_we) begin
							valid_q[ram_waddr] <= 1'b1;
							dirty_q[ram_waddr] <= 1'b0;
						end
					end
					MODE_FREE: begin
						if (found_q) begin
							valid_q[found_slot_q] <= 1'b0;
							dirty_q[found_slot_q] <= 1'b0;
						end
					end
					MODE_MARK: begin
						if (found_q) begin
							dirty_q[found_slot_q] <= 1'b1;
						end
					end
					MODE_CLEAR: begin
						valid_q <= '0;
					end
					default: begin
					end
				endcase
			end
			if (vic.load) begin
				seed_q <= vic.seed;
			end
			if (out_ld) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			mode_q <= s_mode;
			id_q   <= ID_BITS'(s_tdata);
		end
		if (state_q == ST_SCAN && !stall) begin
			idx_s1 <= cnt_q[SLOT_W-1:0];
			if (vld_s1) begin
				if (hit_now && !found_q) begin
					found_slot_q <= idx_s1;
				end
				if (!valid_q[idx_s1] && !free_found_q) begin
					free_slot_q <= idx_s1;
				end
				if (dv_now) begin
					pend_slot_q <= idx_s1;
					pend_id_q   <= rdata;
				end
			end
		end
		if (out_ld) begin
			hit_q   <= res_hit;
			slot_q  <= SLOT_OUT_W'(res_slot);
			known_q <= res_known;
			fetch_q <= res_fetch;
			wbv_q   <= res_wbv;
			wbid_q  <= res_wbid;
			last_q  <= res_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {6'b0, wbid_q, wbv_q, fetch_q, known_q, slot_q, hit_q};

`ifndef NO_ASSERTIONS
	a_stall_flush: assert property (@(posedge clk) disable iff (!arst_n)
		stall |-> (mode_q == MODE_FLUSH && pend_q))
		else $error("scan stalled outside a flush with a pending writeback");

	a_alloc_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_go && mode_q == MODE_LOOKUP) |=> valid_q[$past(res_slot)])
		else $error("lookup result slot not valid afterwards");

	a_s1_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_SCAN) |-> !vld_s1)
		else $error("scan stage busy outside the scan state");

	a_fetch_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && fetch_q) |-> (!hit_q && known_q && last_q))
		else $error("fetch request on a hit or without a slot");
`endif

endmodule

// ===== tb/atc_reply_checker.sv =====
// Watches the request, reply and register channels of the associative tag cache,
// predicts every reply from its own copy of slot state and victim generator, and
// compares field by field. Depends on atc_pkg for the mode codes and LFSR taps.
module atc_reply_checker import atc_pkg::*; #(
	parameter int               CACHE_ENTRIES  = 64,
	parameter int               RESERVED_SLOTS = 10,
	parameter logic [2:0]       SEED_ADDR      = 3'd0
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,  // [15:0] object_id
	input  logic [2:0]  s_tuser,  // [2:0] mode
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,  // hit, slot[6], slot_known, fetch_needed,
	                              // writeback_valid, writeback_id[16], zero pad
	input  logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic [31:0] prdata,
	input  logic        pready,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic                  hit;
		logic [SLOT_OUT_W-1:0] slot;
		logic                  known;
		logic                  fetch;
		logic                  wb_valid;
		logic [OBJ_ID_W-1:0]   wb_id;
		logic                  last;
	} reply_t;

	logic                valid_bits [CACHE_ENTRIES];
	logic                dirty_marks[CACHE_ENTRIES];
	logic [OBJ_ID_W-1:0] stored_ids [CACHE_ENTRIES];
	logic [SEED_W-1:0]   seed_reg;
	logic [SEED_W-1:0]   victim_lfsr;
	reply_t              expected_replies[$];

	initial begin
		fail_count = 0;
		pending    = 0;
	end

	function automatic reply_t blank_reply();
		reply_t r;
		r      = '0;
		r.last = 1'b1;
		return r;
	endfunction

	task automatic predict_request(input logic [MODE_W-1:0] mode, input logic [OBJ_ID_W-1:0] id);
		int     hit_at;
		int     take;
		int     dirty_total;
		int     k;
		logic   lsb;
		reply_t r;
		hit_at = -1;
		for (int i = 0; i < CACHE_ENTRIES; i++) begin
			if (hit_at < 0 && valid_bits[i] && stored_ids[i] == id) begin
				hit_at = i;
			end
		end
		r = blank_reply();
		case (mode)
			MODE_LOOKUP: begin
				if (hit_at >= 0) begin
					r.hit   = 1'b1;
					r.slot  = SLOT_OUT_W'(hit_at);
					r.known = 1'b1;
				end else begin
					take = -1;
					for (int i = 0; i < CACHE_ENTRIES; i++) begin
						if (take < 0 && !valid_bits[i]) begin
							take = i;
						end
					end
					if (take < 0) begin
						lsb         = victim_lfsr[0];
						victim_lfsr = victim_lfsr >> 1;
						if (lsb) begin
							victim_lfsr = victim_lfsr ^ LFSR_TAPS;
						end
						take = RESERVED_SLOTS + int'(victim_lfsr) % (CACHE_ENTRIES - RESERVED_SLOTS);
						if (dirty_marks[take]) begin
							r.wb_valid = 1'b1;
							r.wb_id    = stored_ids[take];
						end
					end
					valid_bits[take]  = 1'b1;
					stored_ids[take]  = id;
					dirty_marks[take] = 1'b0;
					r.slot  = SLOT_OUT_W'(take);
					r.known = 1'b1;
					r.fetch = 1'b1;
				end
				expected_replies.push_back(r);
			end
			MODE_FREE, MODE_MARK: begin
				if (hit_at >= 0) begin
					if (mode == MODE_FREE) begin
						valid_bits[hit_at]  = 1'b0;
						dirty_marks[hit_at] = 1'b0;
					end else begin
						dirty_marks[hit_at] = 1'b1;
					end
					r.hit   = 1'b1;
					r.slot  = SLOT_OUT_W'(hit_at);
					r.known = 1'b1;
				end
				expected_replies.push_back(r);
			end
			MODE_FLUSH: begin
				dirty_total = 0;
				for (int i = 0; i < CACHE_ENTRIES; i++) begin
					if (valid_bits[i] && dirty_marks[i]) begin
						dirty_total++;
					end
				end
				if (dirty_total == 0) begin
					expected_replies.push_back(r);
				end
				k = 0;
				for (int i = 0; i < CACHE_ENTRIES; i++) begin
					if (valid_bits[i] && dirty_marks[i]) begin
						k++;
						r          = '0;
						r.slot     = SLOT_OUT_W'(i);
						r.known    = 1'b1;
						r.wb_valid = 1'b1;
						r.wb_id    = stored_ids[i];
						r.last     = (k == dirty_total);
						expected_replies.push_back(r);
					end
				end
			end
			MODE_CLEAR: begin
				for (int i = 0; i < CACHE_ENTRIES; i++) begin
					valid_bits[i] = 1'b0;
				end
				expected_replies.push_back(r);
			end
			default: begin
				expected_replies.push_back(r);
			end
		endcase
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	task automatic check_reply();
		reply_t want;
		reply_t got;
		got.hit      = m_tdata[0];
		got.slot     = m_tdata[6:1];
		got.known    = m_tdata[7];
		got.fetch    = m_tdata[8];
		got.wb_valid = m_tdata[9];
		got.wb_id    = m_tdata[25:10];
		got.last     = m_tlast;
		if (expected_replies.size() == 0) begin
			$display("%0t: unexpected reply, expected none, actual %h last %b",
				$time, m_tdata, m_tlast);
			fail_count++;
		end else begin
			want = expected_replies.pop_front();
			check_field("hit", want.hit, got.hit);
			check_field("slot", want.slot, got.slot);
			check_field("slot_known", want.known, got.known);
			check_field("fetch_needed", want.fetch, got.fetch);
			check_field("writeback_valid", want.wb_valid, got.wb_valid);
			check_field("writeback_id", want.wb_id, got.wb_id);
			check_field("last", want.last, got.last);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CACHE_ENTRIES; i++) begin
				valid_bits[i]  = 1'b0;
				dirty_marks[i] = 1'b0;
				stored_ids[i]  = '0;
			end
			seed_reg    = LFSR_RESET;
			victim_lfsr = LFSR_RESET;
			expected_replies.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				check_reply();
			end
			if (psel && penable && pready && paddr == SEED_ADDR) begin
				if (pwrite) begin
					seed_reg    = pwdata[SEED_W-1:0];
					victim_lfsr = (seed_reg != '0) ? seed_reg : LFSR_RESET;
				end else if (prdata != {16'd0, seed_reg}) begin
					$display("%0t: random_seed readback mismatch, expected %0d, actual %0d",
						$time, seed_reg, prdata);
					fail_count++;
				end
			end
			if (s_tvalid && s_tready) begin
				predict_request(s_tuser, s_tdata);
			end
		end
		pending = expected_replies.size();
	end

endmodule

// ===== tb/tb.sv =====
// Top of the associative tag cache testbench: clock, reset, request and register
// stimulus, reply back-pressure and the verdict. Depends on atc_pkg, the block
// and atc_reply_checker.
module tb;
	import atc_pkg::*;

	localparam int               CACHE_ENTRIES  = 64;
	localparam int               RESERVED_SLOTS = 10;
	localparam logic [2:0]       SEED_ADDR      = 3'd0;
	localparam logic [MODE_W-1:0] MODE_SPARE_LO  = 3'd5;
	localparam logic [MODE_W-1:0] MODE_SPARE_MID = 3'd6;
	localparam logic [MODE_W-1:0] MODE_SPARE_HI  = 3'd7;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;  // [15:0] object_id
	logic [2:0]  s_tuser;  // [2:0] mode
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;  // hit, slot[6], slot_known, fetch_needed,
	                       // writeback_valid, writeback_id[16], zero pad
	logic        m_tlast;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int          fail_count;
	int          pending;
	bit          calm = 1'b0;
	int          stall_left = 0;
	logic [15:0] id_pool[128];

	assoc_tag_cache_random_replace #(
		.CACHE_ENTRIES (CACHE_ENTRIES),
		.RESERVED_SLOTS(RESERVED_SLOTS),
		.ID_BITS       (OBJ_ID_W)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	atc_reply_checker #(
		.CACHE_ENTRIES (CACHE_ENTRIES),
		.RESERVED_SLOTS(RESERVED_SLOTS),
		.SEED_ADDR     (SEED_ADDR)
	) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.fail_count(fail_count),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#12000000;
		$display("TEST FAILED");
		$finish;
	end

	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 14);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic send_request(input logic [MODE_W-1:0] mode, input logic [15:0] id);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= id;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic sender_gap(input int cycles);
		@(negedge clk);
		s_tvalid <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	task automatic paced_request(input logic [MODE_W-1:0] mode, input logic [15:0] id);
		if (!calm && $urandom_range(0, 5) == 0) begin
			sender_gap($urandom_range(1, 15));
		end
		send_request(mode, id);
	endtask

	task automatic wait_drained();
		sender_gap(1);
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic apb_access(input logic write, input logic [31:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= write;
		paddr   <= SEED_ADDR;
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic random_request(input bit allow_clear);
		int          r;
		logic [15:0] id;
		r  = $urandom_range(0, 99);
		id = id_pool[$urandom_range(0, 127)];
		if (r < 60) begin
			paced_request(MODE_LOOKUP, id);
		end else if (r < 72) begin
			paced_request(MODE_MARK, id);
		end else if (r < 82) begin
			paced_request(MODE_FREE, id);
		end else if (r < 88) begin
			paced_request(MODE_FLUSH, 16'($urandom_range(0, 65535)));
		end else if (r < 90) begin
			paced_request(allow_clear ? MODE_CLEAR : MODE_LOOKUP, id);
		end else if (r < 93) begin
			paced_request(3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI)),
				16'($urandom_range(0, 65535)));
		end else begin
			paced_request(3'($urandom_range(MODE_LOOKUP, MODE_MARK)),
				16'($urandom_range(0, 65535)));
		end
	endtask

	initial begin
		logic [31:0] seed;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = MODE_LOOKUP;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = SEED_ADDR;
		pwdata   = '0;
		foreach (id_pool[i]) begin
			id_pool[i] = 16'($urandom_range(0, 65535));
		end
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		paced_request(MODE_LOOKUP, 16'h0000);
		paced_request(MODE_LOOKUP, 16'hFFFF);
		paced_request(MODE_LOOKUP, 16'h0000);
		paced_request(MODE_MARK, 16'hFFFF);
		paced_request(MODE_MARK, 16'h1234);
		paced_request(MODE_FLUSH, 16'hFFFF);
		paced_request(MODE_FREE, 16'h1234);
		paced_request(MODE_FREE, 16'h0000);
		paced_request(MODE_LOOKUP, 16'hAAAA);
		paced_request(MODE_LOOKUP, 16'h5555);
		paced_request(MODE_MARK, 16'h5555);
		paced_request(MODE_MARK, 16'hAAAA);
		paced_request(MODE_FLUSH, 16'h0000);
		paced_request(MODE_CLEAR, 16'hFFFF);
		paced_request(MODE_FLUSH, 16'h0000);
		paced_request(MODE_LOOKUP, 16'hFFFF);
		paced_request(MODE_SPARE_LO, 16'h5555);
		paced_request(MODE_SPARE_MID, 16'hAAAA);
		paced_request(MODE_SPARE_HI, 16'hFFFF);
		paced_request(MODE_FREE, 16'hFFFF);

		for (int ph = 0; ph < 4; ph++) begin
			wait_drained();
			calm = (ph == 3);
			case (ph)
				0: seed = 32'd1;
				1: seed = 32'hFFFF;
				2: seed = 32'd0;
				default: seed = 32'($urandom_range(2, 65534));
			endcase
			apb_access(1'b1, seed);
			apb_access(1'b0, '0);
			if (ph == 1) begin
				repeat (64) paced_request(MODE_LOOKUP, 16'($urandom_range(0, 65535)));
			end
			repeat (ph == 1 ? 30 : 38) random_request(ph >= 2);
		end

		wait_drained();
		repeat (CACHE_ENTRIES + 8) @(posedge clk);
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
